### rtl/des_pkg.sv
package des_pkg;

    localparam int SAMPLE_BITS       = 10;
    localparam int WORD_BITS         = 32;
    localparam int CODE_BITS_W       = 3;
    localparam int CFG_DATA_W        = SAMPLE_BITS;
    localparam int CODE_MAX          = (1 << CODE_BITS_W) - 1 + 1 + SAMPLE_BITS;
    localparam int LEN_W             = $clog2(CODE_MAX + 1);
    localparam int CNT_W             = $clog2(WORD_BITS);
    localparam int VBITS_W           = $clog2(WORD_BITS + 1);
    localparam int SUM_W             = $clog2(WORD_BITS + CODE_MAX);
    localparam int QUEUE_DEPTH       = 4;

    localparam logic [CODE_BITS_W-1:0] CODE_BITS_MIN     = CODE_BITS_W'(2);
    localparam logic [CODE_BITS_W-1:0] CODE_BITS_RESET   = CODE_BITS_W'(4);
    localparam logic [SAMPLE_BITS-1:0] START_VALUE_RESET = SAMPLE_BITS'(511);

    typedef enum logic [0:0] {
        REG_CODE_BITS   = 1'b0,
        REG_START_VALUE = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic                   end_of_stream;
    } t_in_beat;

    typedef struct packed {
        logic [WORD_BITS-1:0] packed_word;
        logic [VBITS_W-1:0]   valid_bits;
        logic                 final_word;
    } t_out_beat;

    typedef struct packed {
        logic [CODE_MAX-1:0] code;
        logic [LEN_W-1:0]    len;
        logic                last;
    } t_code;

endpackage

### rtl/des_front.sv
module des_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  des_pkg::t_in_beat             i_in_beat,
    input  logic                          i_cfg_valid,
    input  des_pkg::t_cfg_index           i_cfg_index,
    input  logic [des_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_q_ready,
    output logic                          o_push,
    output des_pkg::t_code                o_code
);
    import des_pkg::*;

    logic [CODE_BITS_W-1:0] r_code_bits;
    logic [SAMPLE_BITS-1:0] r_start_value;
    logic [SAMPLE_BITS-1:0] r_prev;
    logic                   r_at_start;

    logic [CODE_BITS_W-1:0] cb;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   negative;
    logic [SAMPLE_BITS-1:0] mag;
    logic                   fits;
    logic [CODE_MAX-1:0]    short_rv;
    logic [CODE_MAX-1:0]    esc_rv;
    logic [LEN_W-1:0]       len;
    logic                   accept;

    assign o_in_ready = i_q_ready;
    assign accept     = i_in_valid && i_q_ready;
    assign o_push     = accept;

    always_comb begin
        cb       = (r_code_bits < CODE_BITS_MIN) ? CODE_BITS_MIN : r_code_bits;
        sample   = i_in_beat.sample;
        negative = sample < r_prev;
        mag      = negative ? (r_prev - sample) : (sample - r_prev);
        fits     = (mag >> (cb - CODE_BITS_W'(1))) == '0;
        short_rv = (CODE_MAX'(negative) << (cb - CODE_BITS_W'(1))) | CODE_MAX'(mag);
        esc_rv   = (CODE_MAX'(1) << (LEN_W'(cb) + LEN_W'(SAMPLE_BITS)))
                 | (CODE_MAX'(negative) << SAMPLE_BITS)
                 | CODE_MAX'(mag);
        len      = fits ? LEN_W'(cb) : (LEN_W'(cb) + LEN_W'(SAMPLE_BITS + 1));
        o_code.len  = len;
        o_code.last = i_in_beat.end_of_stream;
        o_code.code = (fits ? short_rv : esc_rv) << (LEN_W'(CODE_MAX) - len);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_bits   <= CODE_BITS_RESET;
            r_start_value <= START_VALUE_RESET;
            r_prev        <= START_VALUE_RESET;
            r_at_start    <= 1'b1;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_CODE_BITS: begin
                        r_code_bits <= i_cfg_data[CODE_BITS_W-1:0];
                    end
                    REG_START_VALUE: begin
                        r_start_value <= i_cfg_data[SAMPLE_BITS-1:0];
                        if (r_at_start) begin
                            r_prev <= i_cfg_data[SAMPLE_BITS-1:0];
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (accept) begin
                r_prev     <= i_in_beat.end_of_stream ? r_start_value : sample;
                r_at_start <= i_in_beat.end_of_stream;
            end
        end
    end

endmodule

### rtl/des_queue.sv
module des_queue #(
    parameter int DEPTH = des_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  des_pkg::t_code i_data,
    output logic           o_ready,
    output logic           o_valid,
    input  logic           i_pop,
    output des_pkg::t_code o_data
);
    import des_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);

    t_code            r_mem [DEPTH];
    logic [PTR_W:0]   r_wr_ptr;
    logic [PTR_W:0]   r_rd_ptr;

    assign o_valid = r_wr_ptr != r_rd_ptr;
    assign o_ready = !((r_wr_ptr[PTR_W] != r_rd_ptr[PTR_W])
                    && (r_wr_ptr[PTR_W-1:0] == r_rd_ptr[PTR_W-1:0]));
    assign o_data  = r_mem[r_rd_ptr[PTR_W-1:0]];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr[PTR_W-1:0]] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + (PTR_W + 1)'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + (PTR_W + 1)'(1);
            end
        end
    end

endmodule

### rtl/des_back.sv
module des_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  des_pkg::t_code     i_q_data,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output des_pkg::t_out_beat o_out_beat
);
    import des_pkg::*;

    localparam int W = WORD_BITS;

    logic [W-1:0]       r_acc;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_flush_pend;
    logic               r_out_valid;
    t_out_beat          r_out;

    logic               slot_free;
    logic [2*W-1:0]     merged;
    logic [SUM_W-1:0]   sum;
    logic [SUM_W-1:0]   rem;
    logic               full;

    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_pop       = i_q_valid && !r_flush_pend && slot_free;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    always_comb begin
        merged = {r_acc, {W{1'b0}}}
               | ({i_q_data.code, {(2*W-CODE_MAX){1'b0}}} >> r_cnt);
        sum    = SUM_W'(r_cnt) + SUM_W'(i_q_data.len);
        full   = sum >= SUM_W'(W);
        rem    = sum - SUM_W'(W);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc        <= '0;
            r_cnt        <= '0;
            r_flush_pend <= 1'b0;
            r_out_valid  <= 1'b0;
        end else if (r_flush_pend) begin
            if (slot_free) begin
                r_out.packed_word <= r_acc;
                r_out.valid_bits  <= VBITS_W'(r_cnt);
                r_out.final_word  <= 1'b1;
                r_out_valid       <= 1'b1;
                r_acc             <= '0;
                r_cnt             <= '0;
                r_flush_pend      <= 1'b0;
            end
        end else if (o_pop) begin
            if (full) begin
                r_out.packed_word <= merged[2*W-1:W];
                r_out.valid_bits  <= VBITS_W'(W);
                r_out.final_word  <= i_q_data.last && (rem == '0);
                r_out_valid       <= 1'b1;
                if (i_q_data.last && (rem == '0)) begin
                    r_acc <= '0;
                    r_cnt <= '0;
                end else begin
                    r_acc        <= merged[W-1:0];
                    r_cnt        <= CNT_W'(rem);
                    r_flush_pend <= i_q_data.last;
                end
            end else if (i_q_data.last) begin
                r_out.packed_word <= merged[2*W-1:W];
                r_out.valid_bits  <= VBITS_W'(sum);
                r_out.final_word  <= 1'b1;
                r_out_valid       <= 1'b1;
                r_acc             <= '0;
                r_cnt             <= '0;
            end else begin
                r_out_valid <= 1'b0;
                r_acc       <= merged[2*W-1:W];
                r_cnt       <= CNT_W'(sum);
            end
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

### rtl/delta_escape_sample_encoder.sv
// The packer reads one code per cycle from a QUEUE_DEPTH-entry queue into the
//   output register, unless a flush is pending or the output is stalled.
// Throughput: one sample per cycle while the queue has room; one word leaves per
//   cycle when the output is ready, two for a last sample that overflows a word.
// Reset: synchronous, active low; empties queue and packer, restores
//   code_bits to 4, start_value to 511 and the previous sample to 511.
module delta_escape_sample_encoder #(
    parameter int QUEUE_DEPTH = des_pkg::QUEUE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  des_pkg::t_in_beat              i_in_beat,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output des_pkg::t_out_beat             o_out_beat,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  des_pkg::t_cfg_index            i_cfg_index,
    input  logic [des_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import des_pkg::*;

    logic  q_ready;
    logic  q_valid;
    logic  push;
    logic  pop;
    t_code push_code;
    t_code head_code;

    assign o_cfg_ready = 1'b1;

    des_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_beat   (i_in_beat),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_ready   (q_ready),
        .o_push      (push),
        .o_code      (push_code)
    );

    des_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_code),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_data  (head_code)
    );

    des_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_data    (head_code),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_beat  (o_out_beat)
    );

endmodule

### rtl/des_checker.sv
module des_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           o_out_valid,
    input  logic                           i_out_ready,
    input  des_pkg::t_out_beat             o_out_beat
);
    import des_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_beat))
        else $error("output beat dropped or changed while stalled");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    a_full_unless_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_beat.final_word
            |-> o_out_beat.valid_bits == VBITS_W'(WORD_BITS))
        else $error("partial word without final mark");

    a_tail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_beat.valid_bits != '0
            && o_out_beat.valid_bits <= VBITS_W'(WORD_BITS)
            && (o_out_beat.packed_word << o_out_beat.valid_bits) == '0)
        else $error("bad bit count or nonzero unused bits");

endmodule

bind delta_escape_sample_encoder des_checker u_des_checker (.*);
